// ===== rtl/mcpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mcpq_pkg;

  // default sizes
  localparam int NUM_CATEGORIES_DEF = 10;
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int PRIORITY_BITS_DEF  = 8;
  localparam int PAYLOAD_BITS_DEF   = 16;

  // fixed field widths
  localparam int CAT_W    = 4;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_SENT     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_t;

  typedef enum logic {
    CMD_INSERT   = 1'b0,
    CMD_TRANSMIT = 1'b1
  } cmd_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_t             cmd;
    logic             unknown;
    logic [CAT_W-1:0] cat;
  } ctl_t;

  // category count write
  typedef struct packed {
    logic             we;
    logic [CFG_W-1:0] value;
  } cfg_wr_t;

endpackage
`default_nettype wire

// ===== rtl/mcpq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// command word channel
interface mcpq_in_if import mcpq_pkg::*; #(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [CAT_W-1:0]         category;
  logic [PRIORITY_BITS-1:0] priority_req;
  logic [PAYLOAD_BITS-1:0]  payload;

  modport source (output valid, command, category, priority_req, payload, input ready);
  modport sink   (input valid, command, category, priority_req, payload, output ready);
endinterface

// result word channel
interface mcpq_out_if import mcpq_pkg::*; #(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic [PAYLOAD_BITS-1:0]  out_payload;

  modport source (output valid, status, out_priority, out_payload, input ready);
  modport sink   (input valid, status, out_priority, out_payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/mcpq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcpq_front import mcpq_pkg::*; #(
  parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF,
  parameter int PRIORITY_BITS  = PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS   = PAYLOAD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  mcpq_in_if.sink                       in_ch,
  input  wire logic [CFG_W-1:0]         cats_in_use,
  output ctl_t                          q_ctl,
  output logic [PRIORITY_BITS-1:0]      q_prio,
  output logic [PAYLOAD_BITS-1:0]       q_data,
  output logic                          q_valid,
  input  wire logic                     q_pop
);

  ctl_t                     ctl_r  [2];
  logic [PRIORITY_BITS-1:0] prio_r [2];
  logic [PAYLOAD_BITS-1:0]  data_r [2];
  logic                     wr_ptr_r, wr_ptr_nxt;
  logic                     rd_ptr_r, rd_ptr_nxt;
  logic [1:0]               cnt_r, cnt_nxt;
  logic                     push;
  ctl_t                     ctl_in;

  // classify: category at or above the set-up count or the built count is unknown
  always_comb begin
    ctl_in.cmd     = cmd_t'(in_ch.command);
    ctl_in.cat     = in_ch.category;
    ctl_in.unknown = ({1'b0, in_ch.category} >= {1'b0, cats_in_use}) ||
                     ({1'b0, in_ch.category} >= (CAT_W+1)'(NUM_CATEGORIES));
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  // two-entry queue toward the back end
  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_r[wr_ptr_r]  <= ctl_in;
      prio_r[wr_ptr_r] <= in_ch.priority_req;
      data_r[wr_ptr_r] <= in_ch.payload;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_ctl   = ctl_r[rd_ptr_r];
  assign q_prio  = prio_r[rd_ptr_r];
  assign q_data  = data_r[rd_ptr_r];

endmodule
`default_nettype wire

// ===== rtl/mcpq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcpq_back import mcpq_pkg::*; #(
  parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int PRIORITY_BITS  = PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS   = PAYLOAD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ctl_t                     q_ctl,
  input  wire logic [PRIORITY_BITS-1:0] q_prio,
  input  wire logic [PAYLOAD_BITS-1:0]  q_data,
  input  wire logic                     q_valid,
  output logic                          q_pop,
  input  wire cfg_wr_t                  cfg_wr,
  mcpq_out_if.source                    out_ch
);

  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  // sorted cells, one row per category, head at index 0
  logic [PRIORITY_BITS-1:0] prio_r   [NUM_CATEGORIES][QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prio_nxt [NUM_CATEGORIES][QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  data_r   [NUM_CATEGORIES][QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  data_nxt [NUM_CATEGORIES][QUEUE_DEPTH];
  logic [FW-1:0]            fill_r   [NUM_CATEGORIES];
  logic [FW-1:0]            fill_nxt [NUM_CATEGORIES];

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, res_status;
  logic [PRIORITY_BITS-1:0] out_prio_r, res_prio;
  logic [PAYLOAD_BITS-1:0]  out_data_r, res_data;
  logic                     go;

  assign go    = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = go;

  // decode the command against the addressed row
  always_comb begin
    logic [FW-1:0]            sel_fill;
    logic [PRIORITY_BITS-1:0] head_p;
    logic [PAYLOAD_BITS-1:0]  head_d;
    sel_fill = '0;
    head_p   = '0;
    head_d   = '0;
    for (int c = 0; c < NUM_CATEGORIES; c++) begin
      if (q_ctl.cat == CAT_W'(c)) begin
        sel_fill = fill_r[c];
        head_p   = prio_r[c][0];
        head_d   = data_r[c][0];
      end
    end
    res_prio = '0;
    res_data = '0;
    if (q_ctl.unknown) begin
      res_status = ST_UNKNOWN;
    end else if (q_ctl.cmd == CMD_INSERT) begin
      res_status = (sel_fill >= FW'(QUEUE_DEPTH)) ? ST_FULL : ST_INSERTED;
    end else if (sel_fill == '0) begin
      res_status = ST_EMPTY;
    end else begin
      res_status = ST_SENT;
      res_prio   = head_p;
      res_data   = head_d;
    end
  end

  // cell updates: insert shifts the tail right, send shifts left
  always_comb begin
    logic [QUEUE_DEPTH-1:0] ge;
    logic [QUEUE_DEPTH-1:0] ge_prev;
    prio_nxt = prio_r;
    data_nxt = data_r;
    fill_nxt = fill_r;
    ge       = '0;
    ge_prev  = '0;
    for (int c = 0; c < NUM_CATEGORIES; c++) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        ge[k] = (FW'(k) >= fill_r[c]) || (prio_r[c][k] >= q_prio);
      end
      // the first cell at or past the new priority takes the new entry
      ge_prev = {ge[QUEUE_DEPTH-2:0], 1'b0};
      if (go && (q_ctl.cat == CAT_W'(c))) begin
        if (res_status == ST_INSERTED) begin
          fill_nxt[c] = fill_r[c] + FW'(1);
          for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (ge[k]) begin
              if (!ge_prev[k]) begin
                prio_nxt[c][k] = q_prio;
                data_nxt[c][k] = q_data;
              end else begin
                prio_nxt[c][k] = prio_r[c][(k == 0) ? 0 : k - 1];
                data_nxt[c][k] = data_r[c][(k == 0) ? 0 : k - 1];
              end
            end
          end
        end else if (res_status == ST_SENT) begin
          fill_nxt[c] = fill_r[c] - FW'(1);
          for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            prio_nxt[c][k] = prio_r[c][k+1];
            data_nxt[c][k] = data_r[c][k+1];
          end
        end
      end
      // shrinking the category count empties the dropped rows
      if (cfg_wr.we && ((CFG_W+1)'(c) >= {1'b0, cfg_wr.value})) begin
        fill_nxt[c] = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = go ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CATEGORIES; c++) begin
        fill_r[c] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // cell storage and result register
  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    data_r <= data_nxt;
    if (go) begin
      out_status_r <= res_status;
      out_prio_r   <= res_prio;
      out_data_r   <= res_data;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_priority = out_prio_r;
  assign out_ch.out_payload  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/multi_class_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Multi-class priority queue: one sorted queue per category.
// in_ch carries command words: insert (category, priority_req, payload) or
// transmit (pop the lowest priority entry of the category); equal priorities
// pop newest first. out_ch returns exactly one result word per command:
// status, plus priority and payload of the sent entry (zero otherwise).
// An accepted command enters the front queue, then its result is registered
// for out_ch; one command per cycle is sustained while out_ch.ready is high.
// A two-entry queue sits between the classifying front end and the cell
// array, so in_ch.ready drops only when both entries wait behind a stalled
// out_ch; the result register holds its word until out_ch.ready.
// The APB port holds categories_in_use at address 0; writing it empties every
// category at or above the new value. Write it only while idle.
// Reset (rst_n low, synchronous) empties all queues and clears the count to
// zero, so every command reports an unknown category until it is written.
module multi_class_priority_queue import mcpq_pkg::*; #(
  parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int PRIORITY_BITS  = PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS   = PAYLOAD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mcpq_in_if.sink          in_ch,
  mcpq_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CFG_W-1:0]         cats_r;
  cfg_wr_t                  cfg_wr;
  ctl_t                     q_ctl;
  logic [PRIORITY_BITS-1:0] q_prio;
  logic [PAYLOAD_BITS-1:0]  q_data;
  logic                     q_valid;
  logic                     q_pop;

  // register port
  assign pready       = 1'b1;
  assign cfg_wr.we    = psel && penable && pwrite && pready && !paddr[2];
  assign cfg_wr.value = pwdata[CFG_W-1:0];
  assign prdata       = paddr[2] ? 32'd0 : {{(32-CFG_W){1'b0}}, cats_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cats_r <= '0;
    end else if (cfg_wr.we) begin
      cats_r <= cfg_wr.value;
    end
  end

  mcpq_front #(
    .NUM_CATEGORIES (NUM_CATEGORIES),
    .PRIORITY_BITS  (PRIORITY_BITS),
    .PAYLOAD_BITS   (PAYLOAD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cats_in_use (cats_r),
    .q_ctl       (q_ctl),
    .q_prio      (q_prio),
    .q_data      (q_data),
    .q_valid     (q_valid),
    .q_pop       (q_pop)
  );

  mcpq_back #(
    .NUM_CATEGORIES (NUM_CATEGORIES),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .PRIORITY_BITS  (PRIORITY_BITS),
    .PAYLOAD_BITS   (PAYLOAD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_ctl   (q_ctl),
    .q_prio  (q_prio),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .cfg_wr  (cfg_wr),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ===== rtl/mcpq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcpq_checker import mcpq_pkg::*; #(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [STATUS_W-1:0]      status,
  input wire logic [PRIORITY_BITS-1:0] out_priority,
  input wire logic [PAYLOAD_BITS-1:0]  out_payload,
  input wire logic [31:0]              prdata,
  input wire logic [2:0]               paddr
);

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word after reset");

  // only a sent entry carries data
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_SENT) |-> (out_priority == '0) && (out_payload == '0))
    else $error("data on a result that sent nothing");

  // with no categories set up every command is unknown
  a_nocat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (paddr == 3'd0) && (prdata == 32'd0) |-> status == ST_UNKNOWN)
    else $error("category accepted while none set up");

endmodule

bind multi_class_priority_queue mcpq_checker #(
  .PRIORITY_BITS (PRIORITY_BITS),
  .PAYLOAD_BITS  (PAYLOAD_BITS)
) u_mcpq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .out_priority (out_ch.out_priority),
  .out_payload  (out_ch.out_payload),
  .prdata       (prdata),
  .paddr        (paddr)
);
`default_nettype wire

// ===== test/mcpq_checker.sv =====
`timescale 1ns / 1ps
module mcpq_scoreboard import mcpq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire logic        in_command,
  input  wire logic [3:0]  in_category,
  input  wire logic [7:0]  in_priority,
  input  wire logic [15:0] in_payload,
  input  wire logic        out_fire,
  input  wire logic [2:0]  out_status,
  input  wire logic [7:0]  out_priority,
  input  wire logic [15:0] out_payload,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_value,
  output int               fail_count,
  output int               pending,
  output int               sent_count
);
  localparam int NCAT  = NUM_CATEGORIES_DEF;
  localparam int DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  prio;
    logic [15:0] data;
  } result_t;

  logic [7:0]  cell_prio [NCAT][DEPTH];
  logic [15:0] cell_data [NCAT][DEPTH];
  int          fill [NCAT];
  logic [3:0]  cats_in_use;
  result_t     expected_q [$];

  assign pending = expected_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // work out the result of one command and update the queues
  function automatic result_t predict_command(logic cmd, logic [3:0] cat,
                                              logic [7:0] pr, logic [15:0] pl);
    result_t r;
    int pos;
    r = '0;
    if (cat >= cats_in_use || cat >= NCAT) begin
      r.status = ST_UNKNOWN;
    end else if (cmd == CMD_INSERT) begin
      if (fill[cat] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes ahead of equal priorities
        pos = 0;
        while (pos < fill[cat] && cell_prio[cat][pos] < pr) pos++;
        for (int k = fill[cat]; k > pos; k--) begin
          cell_prio[cat][k] = cell_prio[cat][k-1];
          cell_data[cat][k] = cell_data[cat][k-1];
        end
        cell_prio[cat][pos] = pr;
        cell_data[cat][pos] = pl;
        fill[cat]++;
        r.status = ST_INSERTED;
      end
    end else if (fill[cat] == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_SENT;
      r.prio = cell_prio[cat][0];
      r.data = cell_data[cat][0];
      for (int k = 0; k + 1 < fill[cat]; k++) begin
        cell_prio[cat][k] = cell_prio[cat][k+1];
        cell_data[cat][k] = cell_data[cat][k+1];
      end
      fill[cat]--;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      cats_in_use = '0;
      foreach (fill[c]) fill[c] = 0;
      expected_q.delete();
      fail_count = 0;
      sent_count = 0;
    end else begin
      // register write empties categories at or above the new count
      if (cfg_we) begin
        cats_in_use = cfg_value;
        for (int c = 0; c < NCAT; c++) if (c >= cfg_value) fill[c] = 0;
      end
      if (in_fire)
        expected_q.push_back(predict_command(in_command, in_category, in_priority, in_payload));
      // compare the result word with the oldest expectation
      if (out_fire) begin
        if (expected_q.size() == 0) begin
          report("unexpected word", 32'(out_status), 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (want.status == ST_SENT) sent_count++;
          if (out_status !== want.status)
            report("status", 32'(out_status), 32'(want.status));
          if (out_priority !== want.prio)
            report("priority", 32'(out_priority), 32'(want.prio));
          if (out_payload !== want.data)
            report("payload", 32'(out_payload), 32'(want.data));
        end
      end
    end
  end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import mcpq_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, sent_count;
  int          hold_cycles;
  int          items_sent;
  int          writes_done;

  mcpq_in_if  in_ch ();
  mcpq_out_if out_ch ();

  multi_class_priority_queue u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mcpq_scoreboard u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_ch.valid && in_ch.ready), .in_command(in_ch.command),
    .in_category(in_ch.category), .in_priority(in_ch.priority_req),
    .in_payload(in_ch.payload),
    .out_fire(out_ch.valid && out_ch.ready), .out_status(out_ch.status),
    .out_priority(out_ch.out_priority), .out_payload(out_ch.out_payload),
    .cfg_we(psel && penable && pwrite && pready && paddr == 3'd0),
    .cfg_value(pwdata[3:0]),
    .fail_count(fail_count), .pending(pending), .sent_count(sent_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // mostly short gaps, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic cfg_write(input logic [3:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'd0; pwdata <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    writes_done++;
  endtask

  task automatic send_word(input logic cmd, input logic [3:0] cat,
                           input logic [7:0] pr, input logic [15:0] pl);
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.category <= cat;
    in_ch.priority_req <= pr;
    in_ch.payload <= pl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // random command biased toward in-range categories
  task automatic random_word(input int ncat, input bit pop_heavy);
    logic [3:0] cat;
    logic cmd;
    if ($urandom_range(0, 9) == 0 || ncat == 0) cat = 4'($urandom_range(0, 15));
    else cat = 4'($urandom_range(0, ncat - 1));
    cmd = pop_heavy ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 2) == 0);
    send_word(cmd, cat, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    int ncat;
    int settings [6] = '{10, 3, 15, 1, 0, 10};
    hold_cycles = 0;
    items_sent = 0;
    writes_done = 0;
    rst_n <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_ch.valid <= 1'b0; in_ch.command <= 1'b0; in_ch.category <= '0;
    in_ch.priority_req <= '0; in_ch.payload <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: nothing set up yet, then extremes and special cases
    send_word(CMD_INSERT, 4'd0, 8'd5, 16'h1234);
    drain();
    cfg_write(4'd10);
    send_word(CMD_TRANSMIT, 4'd0, 8'd0, 16'd0);
    send_word(CMD_INSERT, 4'd0, 8'd255, 16'hFFFF);
    send_word(CMD_INSERT, 4'd0, 8'd0, 16'h0000);
    send_word(CMD_INSERT, 4'd0, 8'd7, 16'hAAAA);
    send_word(CMD_INSERT, 4'd0, 8'd7, 16'h5555);
    send_word(CMD_INSERT, 4'd9, 8'd1, 16'h0001);
    send_word(CMD_INSERT, 4'd10, 8'd1, 16'h0002);
    send_word(CMD_TRANSMIT, 4'd15, 8'd0, 16'd0);
    for (int i = 0; i < 4; i++) send_word(CMD_TRANSMIT, 4'd0, 8'hFF, 16'hFFFF);
    for (int i = 0; i < 17; i++) send_word(CMD_INSERT, 4'd9, 8'(i * 15), 16'(i));
    drain();
    // shrinking empties category 9, growing again starts it empty
    cfg_write(4'd5);
    cfg_write(4'd10);
    send_word(CMD_TRANSMIT, 4'd9, 8'd0, 16'd0);
    drain();

    // receiver holds off while the sender keeps offering
    hold_cycles = 60;
    for (int i = 0; i < 20; i++) random_word(10, 0);
    drain();

    // random phases over several category counts
    foreach (settings[s]) begin
      ncat = settings[s];
      cfg_write(4'(ncat));
      for (int i = 0; i < 250; i++) begin
        random_word(ncat > 10 ? 10 : ncat, (i / 40) % 2);
        if ($urandom_range(0, 5) == 0) idle_gap();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("run: %0d command words, %0d entries sent, %0d register writes",
             items_sent, sent_count, writes_done);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/mcpq_pkg.sv
rtl/mcpq_if.sv
rtl/mcpq_front.sv
rtl/mcpq_back.sv
rtl/multi_class_priority_queue.sv
rtl/mcpq_checker.sv
test/mcpq_checker.sv
test/tb.sv
